/* hdl/bdq_pkg.sv */
// Shared widths, defaults, operation codes and sequencer states for the bounded deque with search.
package bdq_pkg;

    localparam int DEPTH_DEFAULT = 16;
    localparam int WORD_W        = 32;
    localparam int MODE_W        = 3;
    localparam int OCC_W         = 5;

    // operation codes carried on the mode field
    localparam logic [MODE_W-1:0] MODE_PUSH_FRONT = 3'd0;
    localparam logic [MODE_W-1:0] MODE_PUSH_BACK  = 3'd1;
    localparam logic [MODE_W-1:0] MODE_POP_FRONT  = 3'd2;
    localparam logic [MODE_W-1:0] MODE_POP_BACK   = 3'd3;
    localparam logic [MODE_W-1:0] MODE_SEARCH     = 3'd4;
    localparam logic [MODE_W-1:0] MODE_REVERSE    = 3'd5;

    // sequencer states, one-hot
    typedef enum logic [2:0] {
        S_IDLE = 3'b001,
        S_SCAN = 3'b010,
        S_LAST = 3'b100
    } t_state;

endpackage

/* hdl/bdq_ram.sv */
// Generic single-write, single-read RAM with registered read data.
module bdq_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // write port and registered read port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

/* hdl/bounded_deque_with_search_core.sv */
// Top level of the bounded double-ended queue with linear search.
//
// A transaction is taken when start is high and busy is low; its result
// appears on o_ok and o_occupancy for exactly one cycle with o_valid high,
// and the receiver cannot hold it off. Pushes, pops, reverse and unused
// codes show their result the cycle after acceptance with busy low, so a
// new transaction can follow every cycle. A search walks the stored words
// through the single read port of the entry RAM and one 32-bit comparator:
// busy is high in S_SCAN and S_LAST, and the result is registered from
// S_LAST, which compares the last word. An empty-queue search skips the
// scan; its result shows the cycle after acceptance. Reverse only swaps
// the roles of the two ends. Occupancy is the stored count taken modulo 32.
module bounded_deque_with_search_core #(
    parameter int DEPTH = bdq_pkg::DEPTH_DEFAULT
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              start,
    output logic                              busy,
    input  logic        [bdq_pkg::MODE_W-1:0] i_mode,
    input  logic signed [bdq_pkg::WORD_W-1:0] i_value,
    output logic                              o_valid,
    output logic                              o_ok,
    output logic        [bdq_pkg::OCC_W-1:0]  o_occupancy
);
    import bdq_pkg::*;

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);
    localparam int SW = AW + 2;

    localparam logic [AW-1:0] LAST_SLOT = AW'(DEPTH - 1);
    localparam logic [CW-1:0] FULL_CNT  = CW'(DEPTH);
    localparam logic [SW-1:0] DEPTH_S   = SW'(DEPTH);

    t_state              r_state, n_state;
    logic [AW-1:0]       r_front, n_front;
    logic [CW-1:0]       r_count, n_count;
    logic                r_rev, n_rev;
    logic                r_valid, n_valid;
    logic                r_cmp_vld, n_cmp_vld;
    logic                r_ok, n_ok;
    logic                r_hit, n_hit;
    logic [AW-1:0]       r_ptr, n_ptr;
    logic [CW-1:0]       r_left, n_left;
    logic [WORD_W-1:0]   r_key, n_key;

    logic                accept;
    logic                full, empty;
    logic                at_phys_front;
    logic [AW-1:0]       front_dec, front_inc, ptr_inc, back_slot;
    logic [SW-1:0]       back_sum;
    logic                ram_we;
    logic [AW-1:0]       ram_waddr;
    logic [WORD_W-1:0]   ram_rdata;
    logic                match;

    bdq_ram #(
        .WIDTH (WORD_W),
        .DEPTH (DEPTH)
    ) u_store (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (i_value),
        .i_raddr (r_ptr),
        .o_rdata (ram_rdata)
    );

    assign busy   = !r_state[0];
    assign accept = start && !busy;
    assign full   = (r_count == FULL_CNT);
    assign empty  = (r_count == '0);
    assign match  = (ram_rdata == r_key);

    // ring pointer arithmetic, wrapping at DEPTH
    assign front_dec = (r_front == '0) ? LAST_SLOT : r_front - AW'(1);
    assign front_inc = (r_front == LAST_SLOT) ? '0 : r_front + AW'(1);
    assign ptr_inc   = (r_ptr == LAST_SLOT) ? '0 : r_ptr + AW'(1);
    assign back_sum  = SW'(r_front) + SW'(r_count);
    assign back_slot = (back_sum >= DEPTH_S) ? AW'(back_sum - DEPTH_S) : AW'(back_sum);

    // logical front maps to the physical front unless reversed
    assign at_phys_front = ((i_mode == MODE_PUSH_FRONT) || (i_mode == MODE_POP_FRONT)) ^ r_rev;

    // sequencer and operation decode
    always_comb begin
        n_state   = r_state;
        n_front   = r_front;
        n_count   = r_count;
        n_rev     = r_rev;
        n_valid   = 1'b0;
        n_cmp_vld = r_cmp_vld;
        n_ok      = r_ok;
        n_hit     = r_hit;
        n_ptr     = r_ptr;
        n_left    = r_left;
        n_key     = r_key;
        ram_we    = 1'b0;
        ram_waddr = back_slot;
        unique case (r_state)
            S_IDLE: begin
                if (accept) begin
                    n_valid = 1'b1;
                    n_ok    = 1'b0;
                    unique case (i_mode)
                        MODE_PUSH_FRONT, MODE_PUSH_BACK: begin
                            if (!full) begin
                                ram_we  = 1'b1;
                                n_count = r_count + CW'(1);
                                n_ok    = 1'b1;
                                if (at_phys_front) begin
                                    ram_waddr = front_dec;
                                    n_front   = front_dec;
                                end
                            end
                        end
                        MODE_POP_FRONT, MODE_POP_BACK: begin
                            if (!empty) begin
                                n_count = r_count - CW'(1);
                                n_ok    = 1'b1;
                                if (at_phys_front) begin
                                    n_front = front_inc;
                                end
                            end
                        end
                        MODE_SEARCH: begin
                            if (!empty) begin
                                n_valid   = 1'b0;
                                n_state   = S_SCAN;
                                n_ptr     = r_front;
                                n_left    = r_count;
                                n_key     = i_value;
                                n_cmp_vld = 1'b0;
                                n_hit     = 1'b0;
                            end
                        end
                        MODE_REVERSE: begin
                            n_rev = !r_rev;
                            n_ok  = 1'b1;
                        end
                        default: begin
                            n_ok = 1'b0;
                        end
                    endcase
                end
            end
            S_SCAN: begin
                // issue one read per cycle, compare the word read last cycle
                n_hit     = r_hit || (r_cmp_vld && match);
                n_ptr     = ptr_inc;
                n_left    = r_left - CW'(1);
                n_cmp_vld = 1'b1;
                if (r_left == CW'(1)) begin
                    n_state = S_LAST;
                end
            end
            S_LAST: begin
                n_valid = 1'b1;
                n_ok    = r_hit || match;
                n_state = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_front   <= '0;
            r_count   <= '0;
            r_rev     <= 1'b0;
            r_valid   <= 1'b0;
            r_cmp_vld <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_front   <= n_front;
            r_count   <= n_count;
            r_rev     <= n_rev;
            r_valid   <= n_valid;
            r_cmp_vld <= n_cmp_vld;
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        r_ok   <= n_ok;
        r_hit  <= n_hit;
        r_ptr  <= n_ptr;
        r_left <= n_left;
        r_key  <= n_key;
    end

    assign o_valid     = r_valid;
    assign o_ok        = r_ok;
    assign o_occupancy = OCC_W'(r_count);

endmodule

/* dv/bounded_deque_with_search_core_tb.sv */
`timescale 1ns / 100ps
// Self-checking testbench for the bounded deque with search: stimulus, prediction, result check.
module bounded_deque_with_search_core_tb;
    import bdq_pkg::*;

    localparam int DEPTH        = DEPTH_DEFAULT;
    localparam int RANDOM_ITEMS = 600;
    localparam int IDLE_LIMIT   = 2000;
    localparam int MAX_REPORTS  = 10;

    // codes outside the defined operations, used as noise
    localparam logic [MODE_W-1:0] MODE_SPARE_6 = 3'd6;
    localparam logic [MODE_W-1:0] MODE_SPARE_7 = 3'd7;

    typedef struct packed {
        logic             ok;
        logic [OCC_W-1:0] occupancy;
    } t_deque_status;

    // Deque predictor plus the queue of statuses still to come back
    class deque_scoreboard;
        logic [WORD_W-1:0] words [DEPTH];
        int unsigned       head;
        int unsigned       count;
        bit                flipped;
        t_deque_status     pending_status [$];
        int unsigned       mismatches;

        function new();
            head       = 0;
            count      = 0;
            flipped    = 1'b0;
            mismatches = 0;
        endfunction

        function bit push_at_head(logic [WORD_W-1:0] v);
            if (count >= DEPTH) return 1'b0;
            head        = (head + DEPTH - 1) % DEPTH;
            words[head] = v;
            count++;
            return 1'b1;
        endfunction

        function bit push_at_tail(logic [WORD_W-1:0] v);
            if (count >= DEPTH) return 1'b0;
            words[(head + count) % DEPTH] = v;
            count++;
            return 1'b1;
        endfunction

        function bit drop_head();
            if (count == 0) return 1'b0;
            head = (head + 1) % DEPTH;
            count--;
            return 1'b1;
        endfunction

        function bit drop_tail();
            if (count == 0) return 1'b0;
            count--;
            return 1'b1;
        endfunction

        function bit holds_word(logic [WORD_W-1:0] v);
            for (int unsigned i = 0; i < count; i++) begin
                if (words[(head + i) % DEPTH] == v) return 1'b1;
            end
            return 1'b0;
        endfunction

        // stored word at a given distance from the physical head
        function logic [WORD_W-1:0] word_at(int unsigned idx);
            return words[(head + idx) % DEPTH];
        endfunction

        // one accepted transaction: update the deque, queue its status
        function void note_command(logic [MODE_W-1:0] mode, logic [WORD_W-1:0] v);
            t_deque_status st;
            logic          hit;
            case (mode)
                MODE_PUSH_FRONT: hit = flipped ? push_at_tail(v) : push_at_head(v);
                MODE_PUSH_BACK:  hit = flipped ? push_at_head(v) : push_at_tail(v);
                MODE_POP_FRONT:  hit = flipped ? drop_tail() : drop_head();
                MODE_POP_BACK:   hit = flipped ? drop_head() : drop_tail();
                MODE_SEARCH:     hit = holds_word(v);
                MODE_REVERSE: begin
                    flipped = !flipped;
                    hit     = 1'b1;
                end
                default:         hit = 1'b0;
            endcase
            st.ok        = hit;
            st.occupancy = count[OCC_W-1:0];
            pending_status.push_back(st);
        endfunction

        function void check_result(logic ok, logic [OCC_W-1:0] occupancy);
            t_deque_status want;
            if (pending_status.size() == 0) begin
                mismatches++;
                if (mismatches <= MAX_REPORTS)
                    $display("%0t: unexpected result ok=%0d occupancy=%0d",
                             $realtime, ok, occupancy);
                return;
            end
            want = pending_status.pop_front();
            if (want.ok !== ok || want.occupancy !== occupancy) begin
                mismatches++;
                if (mismatches <= MAX_REPORTS)
                    $display("%0t: mismatch ok exp %0d got %0d, occupancy exp %0d got %0d",
                             $realtime, want.ok, ok, want.occupancy, occupancy);
            end
        endfunction

        function bit failed();
            return (mismatches != 0) || (pending_status.size() != 0);
        endfunction
    endclass

    logic                i_clk;
    logic                i_rst_n;
    logic                start;
    logic                busy;
    logic [MODE_W-1:0]   i_mode;
    logic [WORD_W-1:0]   i_value;
    logic                o_valid;
    logic                o_ok;
    logic [OCC_W-1:0]    o_occupancy;

    deque_scoreboard     sb;
    int unsigned         idle_cycles;

    bounded_deque_with_search_core #(
        .DEPTH(DEPTH)
    ) u_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .start       (start),
        .busy        (busy),
        .i_mode      (i_mode),
        .i_value     (i_value),
        .o_valid     (o_valid),
        .o_ok        (o_ok),
        .o_occupancy (o_occupancy)
    );

    // 2 ns clock
    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    // monitor: check results first, then log the transaction taken at this edge
    always @(posedge i_clk) begin
        if (i_rst_n && sb != null) begin
            if (o_valid) sb.check_result(o_ok, o_occupancy);
            if (start && !busy) sb.note_command(i_mode, i_value);
        end
    end

    // watchdog: cycles with neither an accepted command nor a result
    always @(posedge i_clk) begin
        if (start && !busy && i_rst_n || o_valid)
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
    end

    initial begin
        idle_cycles = 0;
        while (idle_cycles < IDLE_LIMIT) @(posedge i_clk);
        $display("bounded_deque_with_search_core_tb NOT OK");
        $finish;
    end

    // mostly short gaps, a few long; none at all in quiet stretches
    function automatic int pick_gap(bit quiet);
        int r;
        r = $urandom_range(0, 99);
        if (quiet || r < 60) return 0;
        if (r < 90) return $urandom_range(1, 3);
        return $urandom_range(4, 20);
    endfunction

    function automatic logic [WORD_W-1:0] random_word();
        case ($urandom_range(0, 15))
            0:       return 32'h8000_0000;
            1:       return 32'h7FFF_FFFF;
            2:       return 32'h0000_0000;
            3:       return 32'hFFFF_FFFF;
            default: return $urandom;
        endcase
    endfunction

    // drive one command and hold it until the block takes it
    task automatic send_op(input logic [MODE_W-1:0] mode, input logic [WORD_W-1:0] v,
                           input int gap);
        if (gap > 0) begin
            start   <= 1'b0;
            i_mode  <= MODE_W'($urandom);
            i_value <= $urandom;
            repeat (gap) @(posedge i_clk);
        end
        start   <= 1'b1;
        i_mode  <= mode;
        i_value <= v;
        do @(posedge i_clk); while (busy);
    endtask

    // search word: when the deque holds words, half the time one that is stored
    function automatic logic [WORD_W-1:0] search_word();
        if (sb.count != 0 && $urandom_range(0, 1))
            return sb.word_at($urandom_range(0, sb.count - 1));
        return random_word();
    endfunction

    initial begin
        int                issued;
        int                seg_len;
        int                r;
        bit                quiet;
        logic [MODE_W-1:0] mode;

        sb      = new();
        issued  = 0;
        start   <= 1'b0;
        i_mode  <= MODE_PUSH_FRONT;
        i_value <= '0;
        i_rst_n <= 1'b0;
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed: empty store, spare codes, extremes, both directions
        send_op(MODE_SEARCH,     32'h0000_0000, 0);
        send_op(MODE_POP_FRONT,  32'h0000_0000, 0);
        send_op(MODE_POP_BACK,   32'h0000_0000, 1);
        send_op(MODE_REVERSE,    32'h0000_0000, 0);
        send_op(MODE_SPARE_6,    32'hFFFF_FFFF, 0);
        send_op(MODE_SPARE_7,    32'h8000_0000, 2);
        send_op(MODE_PUSH_FRONT, 32'h8000_0000, 0);
        send_op(MODE_PUSH_BACK,  32'h7FFF_FFFF, 0);
        send_op(MODE_PUSH_FRONT, 32'h0000_0000, 0);
        send_op(MODE_PUSH_BACK,  32'hFFFF_FFFF, 0);
        send_op(MODE_SEARCH,     32'h8000_0000, 0);
        send_op(MODE_SEARCH,     32'hFFFF_FFFF, 3);
        send_op(MODE_SEARCH,     32'h0000_0001, 0);
        send_op(MODE_SEARCH,     32'h7FFF_FFFE, 0);
        send_op(MODE_REVERSE,    32'h0000_0000, 0);
        send_op(MODE_POP_FRONT,  32'h0000_0000, 0);
        send_op(MODE_POP_BACK,   32'h0000_0000, 0);
        send_op(MODE_SEARCH,     32'h7FFF_FFFF, 0);
        send_op(MODE_SEARCH,     32'h8000_0000, 0);
        send_op(MODE_SPARE_6,    32'h0000_0000, 0);

        // random: fill runs past full, drain runs past empty, mixed traffic
        while (issued < RANDOM_ITEMS) begin
            quiet = ($urandom_range(0, 3) == 0);
            r     = $urandom_range(0, 9);
            if (r < 2) begin
                for (int i = 0; i < DEPTH + 2; i++) begin
                    mode = $urandom_range(0, 1) ? MODE_PUSH_FRONT : MODE_PUSH_BACK;
                    send_op(mode, random_word(), pick_gap(quiet));
                    issued++;
                end
            end else if (r < 4) begin
                for (int i = 0; i < DEPTH + 2; i++) begin
                    mode = $urandom_range(0, 1) ? MODE_POP_FRONT : MODE_POP_BACK;
                    send_op(mode, random_word(), pick_gap(quiet));
                    issued++;
                end
            end else begin
                seg_len = $urandom_range(8, 24);
                for (int i = 0; i < seg_len; i++) begin
                    r = $urandom_range(0, 99);
                    if (r < 30) begin
                        mode = $urandom_range(0, 1) ? MODE_PUSH_FRONT : MODE_PUSH_BACK;
                        send_op(mode, random_word(), pick_gap(quiet));
                        issued++;
                    end else if (r < 55) begin
                        mode = $urandom_range(0, 1) ? MODE_POP_FRONT : MODE_POP_BACK;
                        send_op(mode, random_word(), pick_gap(quiet));
                        issued++;
                    end else if (r < 82) begin
                        send_op(MODE_SEARCH, search_word(), pick_gap(quiet));
                        issued++;
                    end else if (r < 96) begin
                        send_op(MODE_REVERSE, random_word(), pick_gap(quiet));
                        issued++;
                    end else begin
                        mode = $urandom_range(0, 1) ? MODE_SPARE_6 : MODE_SPARE_7;
                        send_op(mode, random_word(), pick_gap(quiet));
                    end
                end
            end
        end

        // drain: wait out pending statuses, then a search's worth of cycles
        start <= 1'b0;
        while (sb.pending_status.size() != 0) @(posedge i_clk);
        repeat (DEPTH + 4) @(posedge i_clk);

        if (sb.failed())
            $display("bounded_deque_with_search_core_tb NOT OK");
        else
            $display("bounded_deque_with_search_core_tb OK");
        $finish;
    end

endmodule
